// ===== design/bcm_pkg.sv =====
// Shared constants and types for the battery charge monitor.
package bcm_pkg;

    // Sample and threshold width
    localparam int SAMPLE_BITS = 12;

    // Tick counts that govern full detection, level dwell and probe slots, and the near-full margin
    localparam int FULL_CONFIRM_TICKS = 1000;
    localparam int PLATEAU_TICKS      = 65500;
    localparam int LEVEL_DWELL_TICKS  = 600;
    localparam int PROBE_PERIOD       = 4;
    localparam int NEAR_FULL_MARGIN   = 6;

    // Counter widths derived from the tick counts, and the level code width
    localparam int OVER_W  = $clog2(FULL_CONFIRM_TICKS + 2);
    localparam int PLAT_W  = $clog2(PLATEAU_TICKS + 2);
    localparam int DWELL_W = $clog2(LEVEL_DWELL_TICKS + 1);
    localparam int PHASE_W = $clog2(PROBE_PERIOD);
    localparam int LEVEL_W = 2;

    // Stream and configuration widths
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_THR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO_THR = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_BITS-1:0] FULL_THR_RST      = SAMPLE_BITS'(420);
    localparam logic [SAMPLE_BITS-1:0] LEVEL_ONE_THR_RST = SAMPLE_BITS'(370);
    localparam logic [SAMPLE_BITS-1:0] LEVEL_TWO_THR_RST = SAMPLE_BITS'(395);

    // Displayed level codes
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

    // Threshold set
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] full_thr;
        logic [SAMPLE_BITS-1:0] level_one_thr;
        logic [SAMPLE_BITS-1:0] level_two_thr;
    } cfg_t;

    // Per-request step control handed to the state units
    typedef struct packed {
        logic fire;
        logic start;
    } step_t;

endpackage

// ===== design/bcm_full_detect.sv =====
// Full-charge detection: over-threshold count, peak tracker and plateau count.
module bcm_full_detect
    import bcm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  step_t                  step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] full_thr,
    output logic                   full_next_o
);

    localparam logic [SAMPLE_BITS:0] MARGIN_EXT = (SAMPLE_BITS + 1)'(NEAR_FULL_MARGIN);

    logic                   full_reg,    full_next;
    logic [OVER_W-1:0]      over_reg,    over_next;
    logic [PLAT_W-1:0]      plat_reg,    plat_next;
    logic [SAMPLE_BITS-1:0] peak_reg,    peak_next;
    logic                   near_full;
    logic                   over_full;
    logic                   plat_full;

    assign near_full = ({1'b0, sample} + MARGIN_EXT) > {1'b0, full_thr};

    // Next state for one tick or start request
    always_comb begin
        full_next = full_reg;
        over_next = over_reg;
        plat_next = plat_reg;
        peak_next = peak_reg;
        over_full = 1'b0;
        plat_full = 1'b0;
        if (step.start) begin
            full_next = 1'b0;
            over_next = '0;
            plat_next = '0;
            peak_next = '0;
        end else if (full_reg) begin
            over_next = '0;
            plat_next = '0;
        end else begin
            // Consecutive ticks above the full threshold
            if (sample > full_thr) begin
                over_next = over_reg + 1'b1;
                over_full = over_next > OVER_W'(FULL_CONFIRM_TICKS);
            end else begin
                over_next = '0;
            end
            // Peak loads a sample then steps one a tick; a stalled peak is plateau
            if (near_full) begin
                if (peak_reg < sample) begin
                    plat_next = '0;
                    if (peak_reg == '0) begin
                        peak_next = sample;
                    end else begin
                        peak_next = peak_reg + 1'b1;
                    end
                end else begin
                    plat_next = plat_reg + 1'b1;
                    plat_full = plat_next > PLAT_W'(PLATEAU_TICKS);
                end
            end else begin
                plat_next = '0;
            end
            if (over_full || plat_full) begin
                full_next = 1'b1;
                over_next = '0;
                plat_next = '0;
            end
        end
    end

    assign full_next_o = full_next;

    // State registers advance once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            over_reg <= '0;
            plat_reg <= '0;
            peak_reg <= '0;
        end else if (step.fire) begin
            full_reg <= full_next;
            over_reg <= over_next;
            plat_reg <= plat_next;
            peak_reg <= peak_next;
        end
    end

endmodule

// ===== design/bcm_level_filter.sv =====
// Displayed charge level with direction dwell filtering.
module bcm_level_filter
    import bcm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  step_t                  step,
    input  logic                   level_en,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  cfg_t                   cfg,
    output logic [LEVEL_W-1:0]     shown_next_o
);

    logic [LEVEL_W-1:0] shown_reg, shown_next;
    logic [DWELL_W-1:0] dwell_reg, dwell_next;
    logic               up_reg,    up_next;
    logic               down_reg,  down_next;
    logic               first_reg, first_next;
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] base;
    logic [DWELL_W-1:0] dwell_inc;

    // Sampled level from the two thresholds
    always_comb begin
        lvl = LEVEL_LOW;
        if (sample > cfg.level_one_thr) begin
            lvl = (sample > cfg.level_two_thr) ? LEVEL_HIGH : LEVEL_MID;
        end
    end

    // The first check after a start copies the sampled level straight across
    assign base      = first_reg ? lvl : shown_reg;
    assign dwell_inc = dwell_reg + 1'b1;

    // Next state: start clears direction, enabled ticks run the dwell filter
    always_comb begin
        shown_next = shown_reg;
        dwell_next = dwell_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        first_next = first_reg;
        if (step.start) begin
            up_next    = 1'b0;
            down_next  = 1'b0;
            first_next = 1'b1;
        end else if (level_en) begin
            first_next = 1'b0;
            shown_next = base;
            if (lvl > base) begin
                down_next = 1'b0;
                if (up_reg) begin
                    dwell_next = dwell_inc;
                    if (dwell_inc >= DWELL_W'(LEVEL_DWELL_TICKS)) begin
                        dwell_next = '0;
                        shown_next = base + 1'b1;
                    end
                end else begin
                    up_next    = 1'b1;
                    dwell_next = DWELL_W'(1);
                end
            end else if (lvl < base) begin
                up_next = 1'b0;
                if (down_reg) begin
                    dwell_next = dwell_inc;
                    if (dwell_inc >= DWELL_W'(LEVEL_DWELL_TICKS)) begin
                        dwell_next = '0;
                        shown_next = base - 1'b1;
                    end
                end else begin
                    down_next  = 1'b1;
                    dwell_next = DWELL_W'(1);
                end
            end else begin
                up_next   = 1'b0;
                down_next = 1'b0;
            end
        end
    end

    assign shown_next_o = shown_next;

    // State registers advance once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg <= LEVEL_LOW;
            dwell_reg <= '0;
            up_reg    <= 1'b0;
            down_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else if (step.fire) begin
            shown_reg <= shown_next;
            dwell_reg <= dwell_next;
            up_reg    <= up_next;
            down_reg  <= down_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== design/battery_charge_monitor.sv =====
// Top level of the battery charge monitor: stream stages, settings and probe phase.
//
// Usage: each request on the s_axis channel is one 5 ms tick carrying a battery
// sample (tuser low) or a charger-connect start (tuser high). Every request gives
// exactly one result on the m_axis channel: full flag, displayed level, charge
// switch state and probe slot marker.
// Thresholds are written through the cfg channel (index 0 full, 1 level one,
// 2 level two); cfg_ready is always high and writes to other indexes are dropped.
// Write them only while no request is in flight.
// An accepted request is held in the input register, worked on by the compare
// and counter logic, and moves into the result register, which drives
// m_axis_tvalid, once that register is empty or being emptied.
// Throughput: one request per cycle while results are taken, set by the single
// pass from the input register through the state update into the result register.
// Reset (aresetn low, synchronous) empties both stages, restores the default
// thresholds and clears all charge state.
// When m_axis_tready is low the result holds, the input register keeps one
// request, and s_axis_tready drops until the result is taken.
module battery_charge_monitor
    import bcm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [11:0] supply_sample
    input  logic                   s_axis_tuser,   // [0] action
    // Result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [0] full_res, [2:1] charge_level,
                                                   // [3] charge_on, [4] probe_slot
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data
);

    logic                   in_valid_reg,  in_valid_next;
    logic                   in_action_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic [PHASE_W-1:0]     phase_reg,     phase_next;
    cfg_t                   cfg_reg;
    logic                   advance;
    logic                   in_take;
    logic                   is_tick;
    logic                   probe;
    logic                   charge;
    logic                   full_next;
    logic [LEVEL_W-1:0]     shown_next;
    step_t                  step;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_thr      <= FULL_THR_RST;
            cfg_reg.level_one_thr <= LEVEL_ONE_THR_RST;
            cfg_reg.level_two_thr <= LEVEL_TWO_THR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FULL_THR:      cfg_reg.full_thr      <= cfg_data;
                REG_LEVEL_ONE_THR: cfg_reg.level_one_thr <= cfg_data;
                REG_LEVEL_TWO_THR: cfg_reg.level_two_thr <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the held request moves on whenever the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_action_reg <= s_axis_tuser;
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Probe phase: every PROBE_PERIOD-th tick is a disconnect probe slot
    assign is_tick = !in_action_reg;
    assign probe   = is_tick && (phase_reg == PHASE_W'(PROBE_PERIOD - 1));
    assign charge  = is_tick && !probe && !full_next;

    always_comb begin
        phase_next = phase_reg;
        if (is_tick) begin
            phase_next = probe ? '0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
        end
    end

    assign step.fire  = advance;
    assign step.start = in_action_reg;

    bcm_full_detect u_full (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .sample      (in_sample_reg),
        .full_thr    (cfg_reg.full_thr),
        .full_next_o (full_next)
    );

    bcm_level_filter u_level (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .level_en     (charge),
        .sample       (in_sample_reg),
        .cfg          (cfg_reg),
        .shown_next_o (shown_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000, probe, charge, shown_next, full_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The displayed level never takes the unused code.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3))
        else $error("displayed level out of range");

    // Charging is never on while full or in a probe slot.
    a_charge_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[3] && (m_axis_tdata[0] || m_axis_tdata[4])))
        else $error("charge switch on while full or probing");

    // A start request always reports not full and no charging.
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_action_reg) |=> (m_axis_tdata[4:3] == 2'b00 && !m_axis_tdata[0]))
        else $error("start result carries charge state");

    // A stalled result register never takes a new request.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ===== tb/sv/battery_charge_monitor_chk.sv =====
// Checker for the battery charge monitor: tracks the charge state and compares every result.
module battery_charge_monitor_chk
    import bcm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data,
    output int                     result_errors,
    output int                     results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Result word as laid out on m_axis_tdata, highest bits first
    typedef struct packed {
        logic [2:0]         pad;
        logic               probe;
        logic               charge;
        logic [LEVEL_W-1:0] level;
        logic               full;
    } status_t;

    // Thresholds as the block should hold them
    cfg_t thr = '{full_thr: FULL_THR_RST, level_one_thr: LEVEL_ONE_THR_RST,
                  level_two_thr: LEVEL_TWO_THR_RST};

    // Charge state, all starting cleared as after reset
    logic               batt_full   = 1'b0;
    logic [OVER_W-1:0]  over_run    = '0;
    logic [PLAT_W-1:0]  flat_run    = '0;
    logic [SAMPLE_BITS-1:0] peak    = '0;
    logic [PHASE_W-1:0] phase       = '0;
    logic [LEVEL_W-1:0] shown       = LEVEL_LOW;
    logic [DWELL_W-1:0] dwell       = '0;
    logic               rising      = 1'b0;
    logic               falling     = 1'b0;
    logic               fresh_start = 1'b0;

    status_t status_due[$];
    int      results_seen = 0;

    initial begin
        result_errors = 0;
        results_owed  = 0;
    end

    // Full detection: a long run above the threshold, or a near-full plateau of the peak
    function void track_full(input logic [SAMPLE_BITS-1:0] smp);
        if (!batt_full) begin
            if (smp > thr.full_thr) begin
                over_run++;
                if (over_run > FULL_CONFIRM_TICKS)
                    batt_full = 1'b1;
            end else begin
                over_run = '0;
            end
            if (int'(smp) + NEAR_FULL_MARGIN > int'(thr.full_thr)) begin
                if (peak < smp) begin
                    flat_run = '0;
                    if (peak == '0)
                        peak = smp;
                    else
                        peak++;
                end else begin
                    flat_run++;
                    if (flat_run > PLATEAU_TICKS)
                        batt_full = 1'b1;
                end
            end else begin
                flat_run = '0;
            end
        end
        if (batt_full) begin
            over_run = '0;
            flat_run = '0;
        end
    endfunction

    // Displayed level follows the sampled level after a dwell in one direction
    function void track_level(input logic [SAMPLE_BITS-1:0] smp);
        logic [LEVEL_W-1:0] lvl;
        lvl = LEVEL_LOW;
        if (smp > thr.level_one_thr) begin
            lvl = LEVEL_MID;
            if (smp > thr.level_two_thr)
                lvl = LEVEL_HIGH;
        end
        if (fresh_start) begin
            fresh_start = 1'b0;
            shown       = lvl;
        end
        if (lvl > shown) begin
            falling = 1'b0;
            if (rising) begin
                dwell++;
                if (dwell >= LEVEL_DWELL_TICKS) begin
                    dwell = '0;
                    shown++;
                end
            end else begin
                rising = 1'b1;
                dwell  = 1;
            end
        end else if (lvl < shown) begin
            rising = 1'b0;
            if (falling) begin
                dwell++;
                if (dwell >= LEVEL_DWELL_TICKS) begin
                    dwell = '0;
                    shown--;
                end
            end else begin
                falling = 1'b1;
                dwell   = 1;
            end
        end else begin
            rising  = 1'b0;
            falling = 1'b0;
        end
    endfunction

    // One request moves the state on and gives the status it should produce
    function status_t advance_monitor(input logic start, input logic [SAMPLE_BITS-1:0] smp);
        status_t res;
        res = '0;
        if (start) begin
            batt_full   = 1'b0;
            over_run    = '0;
            flat_run    = '0;
            peak        = '0;
            rising      = 1'b0;
            falling     = 1'b0;
            fresh_start = 1'b1;
        end else begin
            track_full(smp);
            if (int'(phase) + 1 >= PROBE_PERIOD) begin
                phase     = '0;
                res.probe = 1'b1;
            end else begin
                phase++;
                if (!batt_full) begin
                    track_level(smp);
                    res.charge = 1'b1;
                end
            end
        end
        res.full  = batt_full;
        res.level = shown;
        return res;
    endfunction

    // Watch the three channels at each edge
    always @(posedge aclk) begin
        status_t got;
        status_t exp;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FULL_THR:      thr.full_thr      = cfg_data;
                    REG_LEVEL_ONE_THR: thr.level_one_thr = cfg_data;
                    REG_LEVEL_TWO_THR: thr.level_two_thr = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(advance_monitor(s_axis_tuser,
                                                     s_axis_tdata[SAMPLE_BITS-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = status_t'(m_axis_tdata);
                if (status_due.size() == 0) begin
                    result_errors++;
                    if (result_errors <= REPORT_LIMIT)
                        $display("%0t: result %0d arrived with no request waiting, data %h",
                                 $realtime, results_seen, m_axis_tdata);
                end else begin
                    exp = status_due.pop_front();
                    if (got.full !== exp.full || got.level !== exp.level ||
                        got.charge !== exp.charge || got.probe !== exp.probe ||
                        got.pad !== exp.pad) begin
                        result_errors++;
                        if (result_errors <= REPORT_LIMIT)
                            $display({"%0t: result %0d wrong: expected full %0d level %0d ",
                                      "on %0d probe %0d pad %0d, got full %0d level %0d ",
                                      "on %0d probe %0d pad %0d"},
                                     $realtime, results_seen, exp.full, exp.level,
                                     exp.charge, exp.probe, exp.pad, got.full, got.level,
                                     got.charge, got.probe, got.pad);
                    end
                end
                results_seen++;
            end
            results_owed = status_due.size();
        end
    end

endmodule

// ===== tb/sv/battery_charge_monitor_tb.sv =====
// Testbench top for the battery charge monitor: clock, reset, request stimulus and verdict.
module battery_charge_monitor_tb;
    import bcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int   NUM_PHASES     = 7;
    localparam int   SHORT_ITEMS    = 70;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam logic ACT_TICK       = 1'b0;
    localparam logic ACT_START      = 1'b1;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [SAMPLE_BITS-1:0] cfg_data      = '0;

    int result_errors;
    int results_owed;
    int reqs_sent     = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int cur_full      = 420;
    int cur_one       = 370;
    int cur_two       = 395;

    battery_charge_monitor dut (.*);

    battery_charge_monitor_chk chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side stalls at random according to the current phase
    always @(posedge aclk)
        m_axis_tready <= (int'($urandom_range(99, 0)) >= snk_stall_pct);

    // Watchdog: give up after a long stretch with no request, result or write accepted
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [SAMPLE_BITS-1:0] to_sample(input int x);
        if (x < 0)
            return '0;
        if (x > SAMPLE_MAX)
            return '1;
        return x[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] near(input int centre, input int spread);
        return to_sample(centre + int'($urandom_range(2 * spread, 0)) - spread);
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait for it to be taken
    task automatic push_req(input logic act, input int smp);
        while (int'($urandom_range(99, 0)) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_TDATA_W'(to_sample(smp));
        do @(posedge aclk); while (!s_axis_tready);
        reqs_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= SAMPLE_BITS'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input int full_thr, input int one_thr, input int two_thr);
        write_reg(REG_FULL_THR, full_thr);
        write_reg(REG_LEVEL_ONE_THR, one_thr);
        write_reg(REG_LEVEL_TWO_THR, two_thr);
        cfg_valid <= 1'b0;
        cur_full = full_thr;
        cur_one  = one_thr;
        cur_two  = two_thr;
    endtask

    // Stop offering requests and wait for every owed result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Low ticks so the first check shows level zero, then a long run above every
    // threshold: the displayed level dwells up one step and the run declares full
    task automatic push_to_full();
        int top_floor;
        top_floor = (cur_one > cur_two) ? cur_one : cur_two;
        top_floor = (cur_full > top_floor) ? cur_full : top_floor;
        push_req(ACT_START, $urandom_range(SAMPLE_MAX, 0));
        repeat (4) push_req(ACT_TICK, 0);
        repeat ($urandom_range(1010, 1002))
            push_req(ACT_TICK, $urandom_range(SAMPLE_MAX, top_floor + 1));
        repeat (8) push_req(ACT_TICK, $urandom_range(SAMPLE_MAX, 0));
    endtask

    // Short charge sessions around the thresholds, climbs and plain noise
    task automatic run_mix(input int budget);
        int stop_at;
        int len;
        int centre;
        int v;
        stop_at = reqs_sent + budget;
        while (reqs_sent < stop_at) begin
            len = $urandom_range(20, 6);
            case ($urandom_range(9, 0))
                0, 1: begin
                    repeat (len)
                        push_req(($urandom_range(19, 0) == 0) ? ACT_START : ACT_TICK,
                                 $urandom_range(SAMPLE_MAX, 0));
                end
                2, 3, 4: begin
                    push_req(ACT_START, $urandom_range(SAMPLE_MAX, 0));
                    case ($urandom_range(3, 0))
                        0:       centre = cur_one;
                        1:       centre = cur_two;
                        2:       centre = cur_full;
                        default: centre = cur_full - NEAR_FULL_MARGIN;
                    endcase
                    repeat (len) push_req(ACT_TICK, near(centre, 4));
                end
                5, 6: begin
                    push_req(ACT_START, $urandom_range(SAMPLE_MAX, 0));
                    v = near(cur_full, 20);
                    repeat (len) begin
                        push_req(ACT_TICK, v);
                        v = v + int'($urandom_range(2, 0));
                    end
                end
                default: begin
                    if ($urandom_range(1, 0) == 1)
                        push_req(ACT_START, $urandom_range(SAMPLE_MAX, 0));
                    centre = $urandom_range(SAMPLE_MAX, 0);
                    repeat (len) push_req(ACT_TICK, near(centre, 2));
                end
            endcase
        end
    endtask

    // Main sequence
    initial begin
        int f;
        int l1;
        int l2;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset thresholds: field extremes, level, near-full and full edges
        push_req(ACT_START, SAMPLE_MAX);
        push_req(ACT_TICK, 0);
        push_req(ACT_TICK, SAMPLE_MAX);
        push_req(ACT_TICK, 370);
        push_req(ACT_TICK, 371);
        push_req(ACT_TICK, 395);
        push_req(ACT_TICK, 396);
        push_req(ACT_TICK, 414);
        push_req(ACT_TICK, 415);
        push_req(ACT_TICK, 420);
        push_req(ACT_TICK, 421);
        push_req(ACT_TICK, 12'hAAA);
        push_req(ACT_TICK, 12'h555);
        // The first check after a start copies the sampled level straight in
        push_req(ACT_START, 0);
        push_req(ACT_TICK, 396);
        repeat (4) push_req(ACT_TICK, 0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
                default: begin src_idle_pct = 33; snk_stall_pct = 33; end
            endcase
            // Threshold sets: reset values, extremes, a full threshold below the near-full
            // margin with level two under level one, a fixed mid-range set, and random sets
            case (p)
                0: begin f = 420;  l1 = 370;  l2 = 395;  end
                1: begin f = SAMPLE_MAX; l1 = 0; l2 = SAMPLE_MAX; end
                2: begin f = 0;    l1 = SAMPLE_MAX; l2 = 0; end
                3: begin f = 3;    l1 = 400;  l2 = 100;  end
                4: begin f = 2048; l1 = 1000; l2 = 3000; end
                default: begin
                    f  = $urandom_range(SAMPLE_MAX, 0);
                    l1 = $urandom_range(SAMPLE_MAX, 0);
                    l2 = $urandom_range(SAMPLE_MAX, 0);
                end
            endcase
            apply_settings(f, l1, l2);
            push_req(ACT_START, SAMPLE_MAX);
            push_req(ACT_TICK, 0);
            push_req(ACT_TICK, SAMPLE_MAX);
            // One long session under stalls on both sides reaches a dwell step and full
            if (p == 3)
                push_to_full();
            run_mix(SHORT_ITEMS / NUM_PHASES);
        end
        settle();

        if (result_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bcm_pkg.sv
design/bcm_full_detect.sv
design/bcm_level_filter.sv
design/battery_charge_monitor.sv
tb/sv/battery_charge_monitor_chk.sv
tb/sv/battery_charge_monitor_tb.sv
